FILE: rtl/named_counting_semaphore_table_top_macros.svh
// Assertion macros for the semaphore table checker.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef NAMED_COUNTING_SEMAPHORE_TABLE_TOP_MACROS_SVH
`define NAMED_COUNTING_SEMAPHORE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define NSCT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("semaphore table check failed");

// Next-cycle implication, checked while out of reset.
`define NSCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("semaphore table check failed");

`endif

FILE: rtl/nsct_pkg.sv
// Shared types, codes and helpers for the named counting semaphore table.
// Depends on nothing; used by every module of the block.
package nsct_pkg;

    localparam int ID_W    = 8;
    localparam int NAME_W  = 64;
    localparam int VALUE_W = 32;
    localparam int PIDIN_W = 8;

    localparam logic [2:0] MODE_OPEN  = 3'd0;
    localparam logic [2:0] MODE_WAIT  = 3'd1;
    localparam logic [2:0] MODE_POST  = 3'd2;
    localparam logic [2:0] MODE_CLOSE = 3'd3;
    localparam logic [2:0] MODE_SET   = 3'd4;
    localparam logic [2:0] MODE_PURGE = 3'd5;

    localparam logic [1:0] KIND_REPLY     = 2'd0;
    localparam logic [1:0] KIND_WAKE_OK   = 2'd1;
    localparam logic [1:0] KIND_WAKE_FAIL = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [15:0] REFS_MAX  = 16'hFFFF;
    localparam logic [31:0] COUNT_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        OP_OPEN,
        OP_WAIT,
        OP_POST,
        OP_CLOSE,
        OP_SET,
        OP_PURGE,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                open_bad;
        logic [ID_W-1:0]     id;
        logic [NAME_W-1:0]   name;
        logic [VALUE_W-1:0]  value;
        logic [PIDIN_W-1:0]  pid;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [3:0] slot;
        logic [7:0] woken_pid;
        logic       last;
    } res_t;

    function automatic res_t make_res(logic [1:0] k, logic [1:0] st, logic [3:0] sl,
                                      logic [7:0] w, logic l);
        res_t r;
        r.kind      = k;
        r.status    = st;
        r.slot      = sl;
        r.woken_pid = w;
        r.last      = l;
        return r;
    endfunction

endpackage

FILE: rtl/nsct_front.sv
// Front end: takes a command item, normalises name and pid, classifies the mode.
// Depends on nsct_pkg.
module nsct_front #(
    parameter int NAME_BYTES = 8,
    parameter int PID_BITS   = 8
) (
    input  logic                         start,
    input  logic                         busy,
    input  logic [2:0]                   mode,
    input  logic [nsct_pkg::ID_W-1:0]    sem_id,
    input  logic [nsct_pkg::NAME_W-1:0]  name,
    input  logic signed [nsct_pkg::VALUE_W-1:0] value,
    input  logic [nsct_pkg::PIDIN_W-1:0] pid,
    output logic                         push,
    output nsct_pkg::cmd_t               cmd
);
    import nsct_pkg::*;

    localparam logic [PIDIN_W-1:0] PID_MASK = PIDIN_W'((17'd1 << PID_BITS) - 17'd1);

    logic [NAME_W-1:0] norm_name;
    logic              alive;
    op_t               op;

    // Bytes from the first zero byte onwards are dropped.
    always_comb
    begin
        norm_name = '0;
        alive     = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (name[8*i +: 8] == 8'd0)
                alive = 1'b0;
            if (alive)
                norm_name[8*i +: 8] = name[8*i +: 8];
        end
    end

    always_comb
    begin
        unique case (mode)
            MODE_OPEN:  op = OP_OPEN;
            MODE_WAIT:  op = OP_WAIT;
            MODE_POST:  op = OP_POST;
            MODE_CLOSE: op = OP_CLOSE;
            MODE_SET:   op = OP_SET;
            MODE_PURGE: op = OP_PURGE;
            default:    op = OP_BAD;
        endcase
    end

    assign push          = start && !busy;
    assign cmd.op        = op;
    assign cmd.open_bad  = (norm_name == '0) || value[VALUE_W-1];
    assign cmd.id        = sem_id;
    assign cmd.name      = norm_name;
    assign cmd.value     = value;
    assign cmd.pid       = pid & PID_MASK;

endmodule

FILE: rtl/nsct_cmdq.sv
// Two-entry command queue between the front end and the executing back end.
// Depends on nsct_pkg.
module nsct_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nsct_pkg::cmd_t push_data,
    input  logic           pop,
    output nsct_pkg::cmd_t pop_data,
    output logic           empty
);
    import nsct_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign empty    = (fill_reg == 2'd0);

endmodule

FILE: rtl/nsct_back.sv
// Back end: the semaphore table, the waiter memory and the operation sequencer.
// Depends on nsct_pkg.
module nsct_back #(
    parameter int NUM_SEMS    = 16,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  nsct_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           idle,
    output logic           res_valid,
    output nsct_pkg::res_t res
);
    import nsct_pkg::*;

    localparam int SW    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QW    = $clog2(QUEUE_DEPTH + 1);
    localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MEM_D = NUM_SEMS * QUEUE_DEPTH;
    localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int WW    = (PID_BITS < 8) ? PID_BITS : 8;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_OPEN_SCAN, S_OPEN_CLAIM, S_POST_WAKE, S_POST_FIN,
        S_REL_RD, S_REL_WAKE, S_CLOSE_FIN, S_PURGE_SLOT, S_PURGE_RD,
        S_PURGE_USE, S_PURGE_NEXT
    } state_t;

    state_t            state_reg;
    cmd_t              cur_reg;
    logic              used_reg  [NUM_SEMS];
    logic [31:0]       count_reg [NUM_SEMS];
    logic [15:0]       refs_reg  [NUM_SEMS];
    logic [NAME_W-1:0] name_reg  [NUM_SEMS];
    logic [QW-1:0]     len_reg   [NUM_SEMS];
    logic [PW-1:0]     head_reg  [NUM_SEMS];
    logic [SW-1:0]     iter_reg;
    logic              free_found_reg;
    logic [SW-1:0]     free_idx_reg;
    logic [QW-1:0]     k_reg;
    logic [QW-1:0]     keep_reg;
    logic              res_valid_reg;
    res_t              res_reg;

    logic [WW-1:0]     waiter_mem [MEM_D];
    logic [WW-1:0]     rd_data_reg;

    logic              in_range;
    logic [SW-1:0]     sid;
    logic              slot_ok;
    logic              cnt_pos;
    logic              wait_queue;
    logic              purge_hit;
    logic [QW-1:0]     keep_next;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [WW-1:0]     mem_wdata;

    function automatic logic [PW-1:0] wrap(logic [PW-1:0] h, logic [QW-1:0] off);
        logic [QW:0] s;
        s = (QW+1)'(h) + (QW+1)'(off);
        if (s >= (QW+1)'(QUEUE_DEPTH))
            s = s - (QW+1)'(QUEUE_DEPTH);
        return s[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(logic [SW-1:0] s, logic [PW-1:0] p);
        return AW'(s * QUEUE_DEPTH + p);
    endfunction

    always_comb
    begin
        in_range   = {1'b0, cur_reg.id} < 9'(NUM_SEMS);
        sid        = in_range ? cur_reg.id[SW-1:0] : '0;
        slot_ok    = in_range && used_reg[sid];
        cnt_pos    = !count_reg[sid][31] && (count_reg[sid] != 32'd0);
        wait_queue = slot_ok && !cnt_pos && (len_reg[sid] < QW'(QUEUE_DEPTH));
        purge_hit  = (rd_data_reg == cur_reg.pid[WW-1:0]);
        keep_next  = keep_reg + QW'(!purge_hit);
    end

    // Waiter memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = cur_reg.pid[WW-1:0];
        mem_raddr = '0;
        unique case (state_reg)
            S_EXEC:
            begin
                mem_raddr = addr_of(sid, head_reg[sid]);
                if (cur_reg.op == OP_WAIT && wait_queue)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(sid, wrap(head_reg[sid], len_reg[sid]));
                end
            end
            S_REL_RD:
                mem_raddr = addr_of(sid, wrap(head_reg[sid], k_reg));
            S_PURGE_RD:
                mem_raddr = addr_of(iter_reg, wrap(head_reg[iter_reg], k_reg));
            S_PURGE_USE:
            begin
                mem_we    = !purge_hit;
                mem_waddr = addr_of(iter_reg, wrap(head_reg[iter_reg], keep_reg));
                mem_wdata = rd_data_reg;
            end
            default:
                mem_raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            waiter_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= waiter_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
            cur_reg        <= '0;
            iter_reg       <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            k_reg          <= '0;
            keep_reg       <= '0;
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                used_reg[i]  <= 1'b0;
                count_reg[i] <= '0;
                refs_reg[i]  <= '0;
                name_reg[i]  <= '0;
                len_reg[i]   <= '0;
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg   <= q_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    unique case (cur_reg.op)
                        OP_OPEN:
                        begin
                            if (cur_reg.open_bad)
                            begin
                                res_valid_reg <= 1'b1;
                                res_reg <= make_res(KIND_REPLY, ST_ERROR, 4'd0, 8'd0, 1'b1);
                            end
                            else
                            begin
                                iter_reg       <= '0;
                                free_found_reg <= 1'b0;
                                state_reg      <= S_OPEN_SCAN;
                            end
                        end
                        OP_WAIT:
                        begin
                            res_valid_reg <= 1'b1;
                            if (!slot_ok)
                                res_reg <= make_res(KIND_REPLY, ST_ERROR, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            else if (cnt_pos)
                            begin
                                count_reg[sid] <= count_reg[sid] - 32'd1;
                                res_reg <= make_res(KIND_REPLY, ST_DONE, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            end
                            else if (!wait_queue)
                                res_reg <= make_res(KIND_REPLY, ST_ERROR, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            else
                            begin
                                len_reg[sid] <= len_reg[sid] + QW'(1);
                                res_reg <= make_res(KIND_REPLY, ST_QUEUED, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            end
                        end
                        OP_POST:
                        begin
                            if (!slot_ok)
                            begin
                                res_valid_reg <= 1'b1;
                                res_reg <= make_res(KIND_REPLY, ST_ERROR, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            end
                            else if (len_reg[sid] != '0)
                                state_reg <= S_POST_WAKE;
                            else
                            begin
                                if (count_reg[sid] != COUNT_MAX)
                                    count_reg[sid] <= count_reg[sid] + 32'd1;
                                res_valid_reg <= 1'b1;
                                res_reg <= make_res(KIND_REPLY, ST_DONE, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (!slot_ok || refs_reg[sid] == 16'd0)
                            begin
                                res_valid_reg <= 1'b1;
                                res_reg <= make_res(KIND_REPLY, ST_ERROR, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            end
                            else
                            begin
                                refs_reg[sid] <= refs_reg[sid] - 16'd1;
                                k_reg         <= '0;
                                if (refs_reg[sid] != 16'd1)
                                begin
                                    res_valid_reg <= 1'b1;
                                    res_reg <= make_res(KIND_REPLY, ST_DONE, cur_reg.id[3:0],
                                                        8'd0, 1'b1);
                                end
                                else if (len_reg[sid] == '0)
                                    state_reg <= S_CLOSE_FIN;
                                else
                                    state_reg <= S_REL_RD;
                            end
                        end
                        OP_SET:
                        begin
                            res_valid_reg <= 1'b1;
                            if (!in_range)
                                res_reg <= make_res(KIND_REPLY, ST_ERROR, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            else
                            begin
                                count_reg[sid] <= cur_reg.value;
                                res_reg <= make_res(KIND_REPLY, ST_DONE, cur_reg.id[3:0],
                                                    8'd0, 1'b1);
                            end
                        end
                        OP_PURGE:
                        begin
                            iter_reg  <= '0;
                            state_reg <= S_PURGE_SLOT;
                        end
                        default:
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg <= make_res(KIND_REPLY, ST_ERROR, 4'd0, 8'd0, 1'b1);
                        end
                    endcase
                end
                S_OPEN_SCAN:
                begin
                    if (used_reg[iter_reg] && name_reg[iter_reg] == cur_reg.name)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (refs_reg[iter_reg] == REFS_MAX)
                            res_reg <= make_res(KIND_REPLY, ST_ERROR, 4'(iter_reg),
                                                8'd0, 1'b1);
                        else
                        begin
                            refs_reg[iter_reg] <= refs_reg[iter_reg] + 16'd1;
                            res_reg <= make_res(KIND_REPLY, ST_DONE, 4'(iter_reg),
                                                8'd0, 1'b1);
                        end
                    end
                    else
                    begin
                        if (!used_reg[iter_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= iter_reg;
                        end
                        if (iter_reg == SW'(NUM_SEMS - 1))
                            state_reg <= S_OPEN_CLAIM;
                        else
                            iter_reg <= iter_reg + SW'(1);
                    end
                end
                S_OPEN_CLAIM:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                    if (free_found_reg)
                    begin
                        used_reg[free_idx_reg]  <= 1'b1;
                        count_reg[free_idx_reg] <= cur_reg.value;
                        refs_reg[free_idx_reg]  <= 16'd1;
                        name_reg[free_idx_reg]  <= cur_reg.name;
                        len_reg[free_idx_reg]   <= '0;
                        res_reg <= make_res(KIND_REPLY, ST_DONE, 4'(free_idx_reg),
                                            8'd0, 1'b1);
                    end
                    else
                        res_reg <= make_res(KIND_REPLY, ST_ERROR, 4'd0, 8'd0, 1'b1);
                end
                S_POST_WAKE:
                begin
                    res_valid_reg  <= 1'b1;
                    res_reg <= make_res(KIND_WAKE_OK, ST_DONE, cur_reg.id[3:0],
                                        8'(rd_data_reg), 1'b0);
                    head_reg[sid] <= wrap(head_reg[sid], QW'(1));
                    len_reg[sid]  <= len_reg[sid] - QW'(1);
                    state_reg     <= S_POST_FIN;
                end
                S_POST_FIN:
                begin
                    res_valid_reg <= 1'b1;
                    res_reg <= make_res(KIND_REPLY, ST_DONE, cur_reg.id[3:0], 8'd0, 1'b1);
                    state_reg <= S_IDLE;
                end
                S_REL_RD:
                    state_reg <= S_REL_WAKE;
                S_REL_WAKE:
                begin
                    res_valid_reg <= 1'b1;
                    res_reg <= make_res(KIND_WAKE_FAIL, ST_DONE, cur_reg.id[3:0],
                                        8'(rd_data_reg), 1'b0);
                    if (k_reg + QW'(1) == len_reg[sid])
                        state_reg <= S_CLOSE_FIN;
                    else
                    begin
                        k_reg     <= k_reg + QW'(1);
                        state_reg <= S_REL_RD;
                    end
                end
                S_CLOSE_FIN:
                begin
                    used_reg[sid]  <= 1'b0;
                    count_reg[sid] <= '0;
                    name_reg[sid]  <= '0;
                    len_reg[sid]   <= '0;
                    res_valid_reg  <= 1'b1;
                    res_reg <= make_res(KIND_REPLY, ST_DONE, cur_reg.id[3:0], 8'd0, 1'b1);
                    state_reg <= S_IDLE;
                end
                S_PURGE_SLOT:
                begin
                    k_reg    <= '0;
                    keep_reg <= '0;
                    if (used_reg[iter_reg] && len_reg[iter_reg] != '0)
                        state_reg <= S_PURGE_RD;
                    else
                        state_reg <= S_PURGE_NEXT;
                end
                S_PURGE_RD:
                    state_reg <= S_PURGE_USE;
                S_PURGE_USE:
                begin
                    keep_reg <= keep_next;
                    if (k_reg + QW'(1) == len_reg[iter_reg])
                    begin
                        len_reg[iter_reg] <= keep_next;
                        state_reg         <= S_PURGE_NEXT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + QW'(1);
                        state_reg <= S_PURGE_RD;
                    end
                end
                S_PURGE_NEXT:
                begin
                    if (iter_reg == SW'(NUM_SEMS - 1))
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg   <= make_res(KIND_REPLY, ST_DONE, 4'd0, 8'd0, 1'b1);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        iter_reg  <= iter_reg + SW'(1);
                        state_reg <= S_PURGE_SLOT;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign idle      = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/named_counting_semaphore_table_top.sv
// Top level of the named counting semaphore table.
// Depends on nsct_pkg, nsct_front, nsct_cmdq and nsct_back.
//
// A table of NUM_SEMS named counting semaphores, each with a FIFO of up to
// QUEUE_DEPTH waiting process ids. An item is taken when start is high and
// busy is low; the block then works on that one item until its reply has been
// shown. Every item yields zero or more wake results and then exactly one
// reply, which carries last. Each result is presented for a single cycle with
// result_strobe high, and the receiver must take it in that cycle, as there
// is no way to hold results back. For wait, set and simple post or close,
// the next item can be taken at the same edge that takes the reply. Open
// walks the table one slot per cycle. A final close reads each waiter in
// a read state and then a wake state, as the waiter memory's read data is
// registered, and purge passes each slot through a slot and a next state
// and each queued waiter through a read and a use state, bound by that
// memory's one read per cycle. After reset the block is ready at once.
module named_counting_semaphore_table_top #(
    parameter int NUM_SEMS    = 16,
    parameter int NAME_BYTES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          mode,
    input  logic [nsct_pkg::ID_W-1:0]           sem_id,
    input  logic [nsct_pkg::NAME_W-1:0]         name,
    input  logic signed [nsct_pkg::VALUE_W-1:0] value,
    input  logic [nsct_pkg::PIDIN_W-1:0]        pid,
    output logic                                result_strobe,
    output logic [1:0]                          kind,
    output logic [1:0]                          status,
    output logic [3:0]                          slot,
    output logic [7:0]                          woken_pid,
    output logic                                last
);
    import nsct_pkg::*;

    logic push;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_empty;
    logic q_pop;
    logic back_idle;
    logic res_valid;
    res_t res;

    // Busy covers an item waiting in the queue and one being carried out.
    assign busy = !q_empty || !back_idle;

    nsct_front #(
        .NAME_BYTES (NAME_BYTES),
        .PID_BITS   (PID_BITS)
    ) u_front (
        .start  (start),
        .busy   (busy),
        .mode   (mode),
        .sem_id (sem_id),
        .name   (name),
        .value  (value),
        .pid    (pid),
        .push   (push),
        .cmd    (push_cmd)
    );

    nsct_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .pop_data  (head_cmd),
        .empty     (q_empty)
    );

    nsct_back #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (head_cmd),
        .q_pop     (q_pop),
        .idle      (back_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result_strobe = res_valid;
    assign kind          = res.kind;
    assign status        = res.status;
    assign slot          = res.slot;
    assign woken_pid     = res.woken_pid;
    assign last          = res.last;

endmodule

FILE: rtl/nsct_checker.sv
// Port-level checker for the semaphore table, with its bind to the top level.
// Depends on nsct_pkg and named_counting_semaphore_table_top_macros.svh.
`include "named_counting_semaphore_table_top_macros.svh"

module nsct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_strobe,
    input logic [1:0] kind,
    input logic [1:0] status,
    input logic       last
);
    import nsct_pkg::*;

    `NSCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `NSCT_ASSERT_NOW(a_reply_last, result_strobe && kind == KIND_REPLY, last)
    `NSCT_ASSERT_NOW(a_wake_not_last, result_strobe && kind != KIND_REPLY, !last)
    `NSCT_ASSERT_NOW(a_wake_status, result_strobe && kind != KIND_REPLY, status == ST_DONE)

endmodule

bind named_counting_semaphore_table_top nsct_checker u_nsct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .kind          (kind),
    .status        (status),
    .last          (last)
);
